### rtl/core/grot_pkg.sv
`default_nettype none

package grot_pkg;

	// Default grid size
	localparam int GRID_W_DEF = 16;
	localparam int GRID_H_DEF = 16;

	// Width of internal coordinate arithmetic (anchor plus size, grid edge up to 64)
	localparam int CW = 7;

	// Operation codes on the op port
	typedef enum logic [1:0] {
		OP_PLACE  = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// One grid cell as held in the cell memory
	typedef struct packed {
		logic        valid;
		logic [15:0] tag;
		logic [3:0]  ax;
		logic [3:0]  ay;
		logic [4:0]  sx;
		logic [4:0]  sy;
	} cell_t;

	localparam int CELL_BITS = $bits(cell_t);

	// Source of the rectangle that the cell cursor walks
	typedef enum logic [1:0] {
		RECT_GRID  = 2'd0,
		RECT_PLACE = 2'd1,
		RECT_FOUND = 2'd2
	} rect_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_PROBE,
		ST_CHECK,
		ST_CHECK_TAIL,
		ST_WRITE,
		ST_FREE,
		ST_CLEAR,
		ST_RESP
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      in_load;
		logic      found_clr;
		logic      found_load;
		logic      rect_load;
		rect_sel_t rect_sel;
		logic      step;
		logic      probe;
		logic      rd_en;
		logic      wr_en;
		logic      wr_place;
		logic      out_load;
		logic      out_ok;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic last;
		logic rd_valid;
		logic place_ok;
		logic in_grid;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/grot_ram.sv
`default_nettype none

module grot_ram #(
	parameter int WIDTH = grot_pkg::CELL_BITS,
	parameter int DEPTH = grot_pkg::GRID_W_DEF * grot_pkg::GRID_H_DEF
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     wr_en,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single port: write, or read with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/grot_ctrl.sv
`default_nettype none

module grot_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  grot_pkg::dp_stat_t stat,
	output grot_pkg::dp_cmd_t  cmd
);

	import grot_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   ok_q;
	logic   ok_d;
	logic   pend_q;

	// State, result flag and read-pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ok_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			pend_q  <= (state_q == ST_CHECK);
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d      = state_q;
		ok_d         = ok_q;
		cmd          = '0;
		cmd.rect_sel = RECT_GRID;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.wr_en = 1'b1;
				cmd.step  = 1'b1;
				if (stat.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.in_load = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.found_clr = 1'b1;
				unique case (stat.op) inside
					OP_PLACE: begin
						if (stat.place_ok) begin
							cmd.rect_load = 1'b1;
							cmd.rect_sel  = RECT_PLACE;
							state_d       = ST_CHECK;
						end else begin
							ok_d    = 1'b0;
							state_d = ST_RESP;
						end
					end
					OP_REMOVE, OP_LOOKUP: begin
						if (stat.in_grid) begin
							cmd.probe = 1'b1;
							cmd.rd_en = 1'b1;
							state_d   = ST_PROBE;
						end else begin
							ok_d    = 1'b0;
							state_d = ST_RESP;
						end
					end
					OP_CLEAR: begin
						cmd.rect_load = 1'b1;
						cmd.rect_sel  = RECT_GRID;
						state_d       = ST_CLEAR;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_PROBE: begin
				if (stat.rd_valid) begin
					cmd.found_load = 1'b1;
					ok_d           = 1'b1;
					if (stat.op == OP_REMOVE) begin
						cmd.rect_load = 1'b1;
						cmd.rect_sel  = RECT_FOUND;
						state_d       = ST_FREE;
					end else begin
						state_d = ST_RESP;
					end
				end else begin
					ok_d    = 1'b0;
					state_d = ST_RESP;
				end
			end
			ST_CHECK: begin
				// Stop at the first taken cell, else keep issuing reads
				if (pend_q && stat.rd_valid) begin
					ok_d    = 1'b0;
					state_d = ST_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.step  = 1'b1;
					if (stat.last) begin
						state_d = ST_CHECK_TAIL;
					end
				end
			end
			ST_CHECK_TAIL: begin
				if (stat.rd_valid) begin
					ok_d    = 1'b0;
					state_d = ST_RESP;
				end else begin
					cmd.rect_load = 1'b1;
					cmd.rect_sel  = RECT_PLACE;
					state_d       = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_place = 1'b1;
				cmd.step     = 1'b1;
				if (stat.last) begin
					ok_d    = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_FREE: begin
				cmd.wr_en = 1'b1;
				cmd.step  = 1'b1;
				if (stat.last) begin
					state_d = ST_RESP;
				end
			end
			ST_CLEAR: begin
				cmd.wr_en = 1'b1;
				cmd.step  = 1'b1;
				if (stat.last) begin
					ok_d    = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// Hand the result over once the output register is free
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_ok   = ok_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/grot_dp.sv
`default_nettype none

module grot_dp #(
	parameter int GRID_W = grot_pkg::GRID_W_DEF,
	parameter int GRID_H = grot_pkg::GRID_H_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         op,
	input  logic [3:0]         pos_x,
	input  logic [3:0]         pos_y,
	input  logic [4:0]         size_x,
	input  logic [4:0]         size_y,
	input  logic [15:0]        item_tag,
	input  grot_pkg::dp_cmd_t  cmd,
	output grot_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               success,
	output logic [15:0]        found_tag,
	output logic [3:0]         found_anchor_x,
	output logic [3:0]         found_anchor_y,
	output logic [4:0]         found_size_x,
	output logic [4:0]         found_size_y
);

	import grot_pkg::*;

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;

	op_t         op_q;
	logic [3:0]  px_q;
	logic [3:0]  py_q;
	logic [4:0]  sx_q;
	logic [4:0]  sy_q;
	logic [15:0] tag_q;

	logic [XW-1:0] x0_q;
	logic [XW-1:0] ex_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] y0_q;
	logic [YW-1:0] ey_q;
	logic [YW-1:0] cy_q;

	cell_t found_q;
	logic  out_valid_q;
	logic  out_ok_q;
	cell_t out_cell_q;

	logic [CW-1:0] pxw;
	logic [CW-1:0] pyw;
	logic [CW-1:0] ld_x0;
	logic [CW-1:0] ld_ex;
	logic [CW-1:0] ld_y0;
	logic [CW-1:0] ld_ey;

	logic [AW-1:0]        addr;
	cell_t                rd_cell;
	cell_t                wr_cell;
	logic [CELL_BITS-1:0] rd_word;
	logic [CELL_BITS-1:0] wr_word;

	// Capture the request on its transfer
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q  <= op_t'(op);
			px_q  <= pos_x;
			py_q  <= pos_y;
			sx_q  <= size_x;
			sy_q  <= size_y;
			tag_q <= item_tag;
		end
	end

	assign pxw = CW'(px_q);
	assign pyw = CW'(py_q);

	// Pick the rectangle bounds to load into the cursor
	always_comb begin
		case (cmd.rect_sel)
			RECT_PLACE: begin
				ld_x0 = pxw;
				ld_y0 = pyw;
				ld_ex = pxw + CW'(sx_q) - CW'(1);
				ld_ey = pyw + CW'(sy_q) - CW'(1);
			end
			RECT_FOUND: begin
				ld_x0 = CW'(rd_cell.ax);
				ld_y0 = CW'(rd_cell.ay);
				ld_ex = CW'(rd_cell.ax) + CW'(rd_cell.sx) - CW'(1);
				ld_ey = CW'(rd_cell.ay) + CW'(rd_cell.sy) - CW'(1);
			end
			default: begin
				ld_x0 = '0;
				ld_y0 = '0;
				ld_ex = CW'(GRID_W - 1);
				ld_ey = CW'(GRID_H - 1);
			end
		endcase
	end

	// Walk the rectangle row by row; reset leaves it on the whole grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= '0;
			y0_q <= '0;
			ex_q <= XW'(GRID_W - 1);
			ey_q <= YW'(GRID_H - 1);
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.rect_load) begin
			x0_q <= ld_x0[XW-1:0];
			y0_q <= ld_y0[YW-1:0];
			ex_q <= ld_ex[XW-1:0];
			ey_q <= ld_ey[YW-1:0];
			cx_q <= ld_x0[XW-1:0];
			cy_q <= ld_y0[YW-1:0];
		end else if (cmd.step) begin
			if (cx_q == ex_q) begin
				cx_q <= x0_q;
				cy_q <= cy_q + YW'(1);
			end else begin
				cx_q <= cx_q + XW'(1);
			end
		end
	end

	// Cell memory access
	assign addr    = cmd.probe ? {pyw[YW-1:0], pxw[XW-1:0]} : {cy_q, cx_q};
	assign wr_cell = cmd.wr_place ? cell_t'{1'b1, tag_q, px_q, py_q, sx_q, sy_q} : '0;
	assign wr_word = wr_cell;
	assign rd_cell = cell_t'(rd_word);

	grot_ram #(
		.WIDTH(CELL_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.addr   (addr),
		.wr_en  (cmd.wr_en),
		.wr_data(wr_word),
		.rd_en  (cmd.rd_en),
		.rd_data(rd_word)
	);

	// Hold the item found at the probed cell
	always_ff @(posedge clk) begin
		if (cmd.found_clr) begin
			found_q <= '0;
		end else if (cmd.found_load) begin
			found_q <= rd_cell;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ok_q   <= cmd.out_ok;
			out_cell_q <= found_q;
		end
	end

	// Status to the controller
	always_comb begin
		stat.op       = op_q;
		stat.last     = (cx_q == ex_q) && (cy_q == ey_q);
		stat.rd_valid = rd_cell.valid;
		stat.place_ok = (sx_q != 5'd0) && (sy_q != 5'd0)
			&& (pxw + CW'(sx_q) <= CW'(GRID_W))
			&& (pyw + CW'(sy_q) <= CW'(GRID_H));
		stat.in_grid  = (pxw < CW'(GRID_W)) && (pyw < CW'(GRID_H));
		stat.out_busy = out_valid_q && out_stall;
	end

	assign out_valid      = out_valid_q;
	assign success        = out_ok_q;
	assign found_tag      = out_cell_q.tag;
	assign found_anchor_x = out_cell_q.ax;
	assign found_anchor_y = out_cell_q.ay;
	assign found_size_x   = out_cell_q.sx;
	assign found_size_y   = out_cell_q.sy;

endmodule

`default_nettype wire

### rtl/core/grid_rectangle_occupancy_table_core.sv
// Rectangle occupancy table over a GRID_W by GRID_H grid of cells, one cell memory
// word per cell, visited through a single memory port at one cell per clock. Each
// request takes one transfer and returns exactly one result. Lookup, and remove or
// lookup of a free cell, probe one cell. Remove then also frees each cell of the item.
// Place reads each covered cell (ending early at the first taken cell) and then
// writes each cell when it succeeds; a placement out of range fails with no memory
// access. Clear writes every cell of the grid. After reset a clearing pass over
// all GRID_W * GRID_H cells runs before the first request is taken. A new request
// is taken while an earlier result still waits on the output; its own result is
// then held back until the earlier one has been transferred.
`default_nettype none

module grid_rectangle_occupancy_table_core #(
	parameter int GRID_W = grot_pkg::GRID_W_DEF,
	parameter int GRID_H = grot_pkg::GRID_H_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  pos_x,
	input  logic [3:0]  pos_y,
	input  logic [4:0]  size_x,
	input  logic [4:0]  size_y,
	input  logic [15:0] item_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        success,
	output logic [15:0] found_tag,
	output logic [3:0]  found_anchor_x,
	output logic [3:0]  found_anchor_y,
	output logic [4:0]  found_size_x,
	output logic [4:0]  found_size_y
);

	import grot_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	grot_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	grot_dp #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.size_x        (size_x),
		.size_y        (size_y),
		.item_tag      (item_tag),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.success       (success),
		.found_tag     (found_tag),
		.found_anchor_x(found_anchor_x),
		.found_anchor_y(found_anchor_y),
		.found_size_x  (found_size_x),
		.found_size_y  (found_size_y)
	);

endmodule

`default_nettype wire

### rtl/core/grot_chk.sv
`default_nettype none

module grot_chk #(
	parameter int GRID_W = grot_pkg::GRID_W_DEF,
	parameter int GRID_H = grot_pkg::GRID_H_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        success,
	input logic [15:0] found_tag,
	input logic [3:0]  found_anchor_x,
	input logic [3:0]  found_anchor_y,
	input logic [4:0]  found_size_x,
	input logic [4:0]  found_size_y
);

	import grot_pkg::*;

	// One request at a time: a transfer is followed by a stall
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while the previous one was still at work");

	// A failed request reports no item
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> found_tag == 16'd0 && found_anchor_x == 4'd0
			&& found_anchor_y == 4'd0 && found_size_x == 5'd0 && found_size_y == 5'd0)
		else $error("failed result carries item fields");

	// Width and height are both empty or both present
	a_size_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((found_size_x == 5'd0) == (found_size_y == 5'd0)))
		else $error("found item has only one empty dimension");

	// A found item lies inside the grid
	a_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_size_x != 5'd0 |->
			(CW'(found_anchor_x) + CW'(found_size_x) <= CW'(GRID_W))
			&& (CW'(found_anchor_y) + CW'(found_size_y) <= CW'(GRID_H)))
		else $error("found item reaches past the grid edge");

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(success) && $stable(found_tag))
		else $error("stalled result changed");

endmodule

bind grid_rectangle_occupancy_table_core grot_chk #(
	.GRID_W(GRID_W),
	.GRID_H(GRID_H)
) u_grot_chk (.*);

`default_nettype wire
